>>> src/cprt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cprt_pkg
// Shared types and codes for the CAN pair receive table.
// ----------------------------------------------------------------------------
package cprt_pkg;

    // item function codes
    localparam logic [1:0] FN_FRAME = 2'd0;
    localparam logic [1:0] FN_POLL  = 2'd1;
    localparam logic [1:0] FN_READ  = 2'd2;

    // configuration register indexes
    localparam logic REG_MAX_INDEX = 1'b0;
    localparam logic REG_DEFERRED  = 1'b1;

    // low bits of the CAN id that name the sending board
    localparam logic [4:0] SENDER_MASK = 5'b11111;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_FRAME,
        S_PUSHV,
        S_RD_WAIT,
        S_D_RDV,
        S_D_WR,
        S_RESP
    } cprt_state_t;

    typedef struct packed {
        logic push;
        logic pop;
    } ring_ctrl_t;

endpackage
`default_nettype wire

>>> src/cprt_ring.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cprt_ring
// Word ring for deferred pairs: one write and one read per cycle, registered
// read data, head/tail pointers and a word count.
// ----------------------------------------------------------------------------
module cprt_ring
    import cprt_pkg::*;
#(
    parameter int RING_WORDS = 64
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire ring_ctrl_t                         ctrl,
    input  wire logic [15:0]                        wr_data,
    output logic [15:0]                             rd_data,
    output logic [$clog2(RING_WORDS + 1) - 1:0]     count
);

    localparam int RING_AW = $clog2(RING_WORDS);
    localparam int RING_CW = $clog2(RING_WORDS + 1);
    localparam logic [RING_AW-1:0] PTR_LAST = RING_AW'(RING_WORDS - 1);

    logic [15:0]        mem [RING_WORDS];
    logic [15:0]        rd_data_reg;
    logic [RING_AW-1:0] head_reg;
    logic [RING_AW-1:0] head_next;
    logic [RING_AW-1:0] tail_reg;
    logic [RING_AW-1:0] tail_next;
    logic [RING_CW-1:0] count_reg;
    logic [RING_CW-1:0] count_next;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (ctrl.push)
        begin
            head_next = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
        end
        if (ctrl.pop)
        begin
            tail_next = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
        end
        if (ctrl.push && !ctrl.pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctrl.pop && !ctrl.push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[head_reg] <= wr_data;
        end
        if (ctrl.pop)
        begin
            rd_data_reg <= mem[tail_reg];
        end
    end

    assign rd_data = rd_data_reg;
    assign count   = count_reg;

endmodule
`default_nettype wire

>>> src/can_pair_receive_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// can_pair_receive_table
// Receive side of a CAN index/value pair transfer with a 16-bit value table.
//
// Input channel (in_valid/in_stall) carries one item: a frame arrival, a
// poll or a table read. Output channel (out_valid/out_stall) returns exactly
// one result per item from an output register, so the next item is taken
// while a result still waits; the block works on one item at a time.
// Steps, accept to result valid:
//   read  : one table read (registered data), then the result
//   frame : one step per pair slot (sender and the two pairs); in deferred
//           mode each queued pair also takes a step for its value word
//   poll  : in deferred mode, drains queued pairs (one ring word read per cycle)
// Config writes (cfg_we/cfg_index/cfg_data) are taken at any edge.
// After reset the table is cleared, one entry per cycle; in_stall stays high
// meanwhile. A stalled receiver holds the result in the output register; the
// next item is still taken and then waits, in_stall high, until it is free.
// ----------------------------------------------------------------------------
module can_pair_receive_table
    import cprt_pkg::*;
#(
    parameter int TABLE_ENTRIES    = 64,
    parameter int RING_WORDS       = 64,
    parameter int LAST_BOARD_INDEX = 3
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [6:0]  cfg_data,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  func,
    input  wire logic [3:0]  frame_length,
    input  wire logic [10:0] frame_id,
    input  wire logic [15:0] first_index,
    input  wire logic [15:0] first_value,
    input  wire logic [15:0] second_index,
    input  wire logic [15:0] second_value,
    input  wire logic [5:0]  read_index,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             new_data,
    output logic [15:0]      read_value,
    output logic             ring_overflow
);

    localparam int TAB_AW  = $clog2(TABLE_ENTRIES);
    localparam int RING_CW = $clog2(RING_WORDS + 1);
    localparam logic [15:0]        TAB_LIMIT  = 16'(TABLE_ENTRIES);
    localparam logic [15:0]        LB_IDX     = 16'(LAST_BOARD_INDEX);
    localparam logic [TAB_AW-1:0]  CLR_LAST   = TAB_AW'(TABLE_ENTRIES - 1);
    localparam logic [RING_CW-1:0] RING_LIMIT = RING_CW'(RING_WORDS - 3);

    // configuration
    logic [6:0] max_index_reg;
    logic       deferred_reg;

    // fsm and working state
    cprt_state_t       state_reg, state_next;
    logic [TAB_AW-1:0] clr_reg, clr_next;
    logic [1:0]        slot_reg, slot_next;
    logic [15:0]       daddr_reg, daddr_next;
    logic              flag_reg, flag_next;
    logic              nd_res_reg, nd_res_next;
    logic [15:0]       rv_res_reg, rv_res_next;
    logic              ovf_res_reg, ovf_res_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic        new_data_reg, new_data_next;
    logic [15:0] read_value_reg, read_value_next;
    logic        ring_overflow_reg, ring_overflow_next;

    // captured item
    logic [1:0]  func_reg;
    logic        two_reg;
    logic [4:0]  sender_reg;
    logic [15:0] i0_reg, v0_reg, i1_reg, v1_reg;
    logic [15:0] ridx_reg;

    // value table
    logic [15:0]       tab_mem [TABLE_ENTRIES];
    logic              tab_we;
    logic [TAB_AW-1:0] tab_waddr;
    logic [15:0]       tab_wdata;
    logic              tab_re;
    logic [15:0]       tab_rdata_reg;

    // ring
    ring_ctrl_t          ring_ctrl;
    logic [15:0]         ring_wdata;
    logic [15:0]         ring_rdata;
    logic [RING_CW-1:0]  ring_count;

    logic        in_xfer;
    logic        ok0, ok1;
    logic        cur_en;
    logic [15:0] cur_idx, cur_val;
    logic        slot_last;
    logic        ring_room;
    logic        resp_load;
    logic        ridx_ok;

    cprt_ring #(
        .RING_WORDS (RING_WORDS)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ring_ctrl),
        .wr_data (ring_wdata),
        .rd_data (ring_rdata),
        .count   (ring_count)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign in_xfer  = in_valid && !in_stall;

    assign ok0 = (i0_reg < {9'd0, max_index_reg}) && (i0_reg < TAB_LIMIT);
    assign ok1 = two_reg && (i1_reg < {9'd0, max_index_reg}) && (i1_reg < TAB_LIMIT);

    // instant mode writes the sender entry first; deferred queues it last
    always_comb
    begin
        cur_en  = 1'b0;
        cur_idx = LB_IDX;
        cur_val = {11'd0, sender_reg};
        case (slot_reg)
            2'd0:
            begin
                if (deferred_reg)
                begin
                    cur_en  = ok0;
                    cur_idx = i0_reg;
                    cur_val = v0_reg;
                end
                else
                begin
                    cur_en = 1'b1;
                end
            end
            2'd1:
            begin
                cur_en  = deferred_reg ? ok1 : ok0;
                cur_idx = deferred_reg ? i1_reg : i0_reg;
                cur_val = deferred_reg ? v1_reg : v0_reg;
            end
            2'd2:
            begin
                cur_en  = deferred_reg ? 1'b1 : ok1;
                cur_idx = deferred_reg ? LB_IDX : i1_reg;
                cur_val = deferred_reg ? {11'd0, sender_reg} : v1_reg;
            end
            default:
            begin
                cur_en = 1'b0;
            end
        endcase
    end

    assign slot_last = (slot_reg == 2'd2);
    assign ring_room = (ring_count < RING_LIMIT);
    assign resp_load = !out_valid_reg || !out_stall;
    assign ridx_ok   = (ridx_reg < TAB_LIMIT);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == CLR_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (func_reg)
                    FN_FRAME:
                    begin
                        state_next = S_FRAME;
                    end
                    FN_POLL:
                    begin
                        if (flag_reg && deferred_reg && (ring_count != '0))
                        begin
                            state_next = S_D_RDV;
                        end
                        else
                        begin
                            state_next = S_RESP;
                        end
                    end
                    FN_READ:
                    begin
                        state_next = S_RD_WAIT;
                    end
                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end
            S_FRAME:
            begin
                if (deferred_reg && cur_en && ring_room)
                begin
                    state_next = S_PUSHV;
                end
                else if (slot_last)
                begin
                    state_next = S_RESP;
                end
            end
            S_PUSHV:
            begin
                state_next = slot_last ? S_RESP : S_FRAME;
            end
            S_RD_WAIT:
            begin
                state_next = S_RESP;
            end
            S_D_RDV:
            begin
                state_next = S_D_WR;
            end
            S_D_WR:
            begin
                state_next = (ring_count != '0) ? S_D_RDV : S_RESP;
            end
            S_RESP:
            begin
                if (resp_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath controls and register updates
    always_comb
    begin
        tab_we             = 1'b0;
        tab_waddr          = clr_reg;
        tab_wdata          = '0;
        tab_re             = 1'b0;
        ring_ctrl          = '0;
        ring_wdata         = cur_idx;
        clr_next           = clr_reg;
        slot_next          = slot_reg;
        daddr_next         = daddr_reg;
        flag_next          = flag_reg;
        nd_res_next        = nd_res_reg;
        rv_res_next        = rv_res_reg;
        ovf_res_next       = ovf_res_reg;
        out_valid_next     = out_valid_reg;
        new_data_next      = new_data_reg;
        read_value_next    = read_value_reg;
        ring_overflow_next = ring_overflow_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                tab_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
            end
            S_DISPATCH:
            begin
                slot_next    = 2'd0;
                nd_res_next  = 1'b0;
                rv_res_next  = '0;
                ovf_res_next = 1'b0;
                case (func_reg)
                    FN_FRAME:
                    begin
                        flag_next = 1'b1;
                    end
                    FN_POLL:
                    begin
                        if (flag_reg)
                        begin
                            flag_next = 1'b0;
                            if (!deferred_reg)
                            begin
                                nd_res_next = 1'b1;
                            end
                            else if (ring_count != '0)
                            begin
                                nd_res_next   = 1'b1;
                                ring_ctrl.pop = 1'b1;
                            end
                        end
                    end
                    FN_READ:
                    begin
                        tab_re = 1'b1;
                    end
                    default:
                    begin
                        tab_re = 1'b0;
                    end
                endcase
            end
            S_FRAME:
            begin
                tab_waddr = cur_idx[TAB_AW-1:0];
                tab_wdata = cur_val;
                if (!deferred_reg)
                begin
                    tab_we    = cur_en && (cur_idx < TAB_LIMIT);
                    slot_next = slot_reg + 1'b1;
                end
                else if (cur_en && ring_room)
                begin
                    ring_ctrl.push = 1'b1;
                    ring_wdata     = cur_idx;
                end
                else
                begin
                    // no ring room or pair not valid: pair is dropped, overflow only if no room
                    if (cur_en)
                    begin
                        ovf_res_next = 1'b1;
                    end
                    slot_next = slot_reg + 1'b1;
                end
            end
            S_PUSHV:
            begin
                ring_ctrl.push = 1'b1;
                ring_wdata     = cur_val;
                slot_next      = slot_reg + 1'b1;
            end
            S_RD_WAIT:
            begin
                rv_res_next = ridx_ok ? tab_rdata_reg : 16'd0;
            end
            S_D_RDV:
            begin
                daddr_next    = ring_rdata;
                ring_ctrl.pop = 1'b1;
            end
            S_D_WR:
            begin
                tab_waddr = daddr_reg[TAB_AW-1:0];
                tab_wdata = ring_rdata;
                tab_we    = (daddr_reg < TAB_LIMIT);
                if (ring_count != '0)
                begin
                    ring_ctrl.pop = 1'b1;
                end
            end
            S_RESP:
            begin
                if (resp_load)
                begin
                    out_valid_next     = 1'b1;
                    new_data_next      = nd_res_reg;
                    read_value_next    = rv_res_reg;
                    ring_overflow_next = ovf_res_reg;
                end
            end
            default:
            begin
                tab_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_index_reg <= '0;
            deferred_reg  <= 1'b0;
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            slot_reg      <= '0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == REG_MAX_INDEX))
            begin
                max_index_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == REG_DEFERRED))
            begin
                deferred_reg <= cfg_data[0];
            end
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            slot_reg      <= slot_next;
            flag_reg      <= flag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        daddr_reg         <= daddr_next;
        nd_res_reg        <= nd_res_next;
        rv_res_reg        <= rv_res_next;
        ovf_res_reg       <= ovf_res_next;
        new_data_reg      <= new_data_next;
        read_value_reg    <= read_value_next;
        ring_overflow_reg <= ring_overflow_next;
        if (in_xfer)
        begin
            func_reg   <= func;
            two_reg    <= (frame_length >= 4'd8);
            sender_reg <= frame_id[4:0] & SENDER_MASK;
            i0_reg     <= first_index;
            v0_reg     <= first_value;
            i1_reg     <= second_index;
            v1_reg     <= second_value;
            ridx_reg   <= {10'd0, read_index};
        end
    end

    always_ff @(posedge clk)
    begin
        if (tab_we)
        begin
            tab_mem[tab_waddr] <= tab_wdata;
        end
        if (tab_re)
        begin
            tab_rdata_reg <= tab_mem[ridx_reg[TAB_AW-1:0]];
        end
    end

    assign out_valid     = out_valid_reg;
    assign new_data      = new_data_reg;
    assign read_value    = read_value_reg;
    assign ring_overflow = ring_overflow_reg;

endmodule
`default_nettype wire
